// ----- hw/rtl/gzhp_pkg.sv -----
package gzhp_pkg;

    // fixed header length and field masks
    localparam int unsigned FIXED_LEN = 10;
    localparam logic [3:0] FIXED_LAST = 4'(FIXED_LEN - 1);
    localparam logic [15:0] LOW16_MASK = 16'hffff;
    localparam logic [31:0] CRC_INIT = 32'hffff_ffff;
    localparam logic [31:0] CRC_POLY = 32'hedb8_8320;
    localparam logic [7:0] MAGIC_0 = 8'h1f;
    localparam logic [7:0] MAGIC_1 = 8'h8b;

    // flag bit positions in the flags byte
    localparam int unsigned FL_HCRC = 1;
    localparam int unsigned FL_EXTRA = 2;
    localparam int unsigned FL_NAME = 3;
    localparam int unsigned FL_COMMENT = 4;

    // status codes
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_CRC_ERR = 2'd2;
    localparam logic [1:0] ST_END = 2'd3;

    typedef enum logic [2:0] {
        PH_FIXED   = 3'd0,
        PH_XLEN    = 3'd1,
        PH_EXTRA   = 3'd2,
        PH_NAME    = 3'd3,
        PH_COMMENT = 3'd4,
        PH_HCRC    = 3'd5,
        PH_PAYLOAD = 3'd6,
        PH_STOP    = 3'd7
    } t_phase;

    // one input word
    typedef struct packed {
        logic       later_member;
        logic       member_start;
        logic [7:0] data_byte;
    } t_item;

    // one result word
    typedef struct packed {
        logic [1:0] status;
        logic       header_done;
        logic       payload_valid;
        logic [7:0] data_out;
    } t_result;

    // crc-32 (reflected) update by one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // first optional section after phase ph whose flag is set, else payload
    function automatic t_phase next_sec(input t_phase ph, input logic [4:0] flags);
        t_phase p;
        p = PH_PAYLOAD;
        if (ph < PH_HCRC && flags[FL_HCRC]) p = PH_HCRC;
        if (ph < PH_COMMENT && flags[FL_COMMENT]) p = PH_COMMENT;
        if (ph < PH_NAME && flags[FL_NAME]) p = PH_NAME;
        if (ph < PH_XLEN && flags[FL_EXTRA]) p = PH_XLEN;
        return p;
    endfunction

endpackage

// ----- hw/rtl/gzhp_parse.sv -----
module gzhp_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  gzhp_pkg::t_item   i_item,
    output gzhp_pkg::t_result o_res
);
    import gzhp_pkg::*;

    t_phase      r_phase, n_phase, e_phase;
    logic [3:0]  r_cnt, n_cnt, e_cnt;
    logic [4:0]  r_flags, n_flags, e_flags;
    logic [15:0] r_extra, n_extra, e_extra;
    logic [31:0] r_crc, n_crc, e_crc;
    logic [7:0]  r_held, n_held, e_held;
    logic [1:0]  r_sticky, n_sticky, e_sticky;
    logic [31:0] w_crc_fed;
    logic [15:0] w_word;
    logic [7:0]  b;

    // parser state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FIXED;
            r_cnt    <= '0;
            r_flags  <= '0;
            r_extra  <= '0;
            r_crc    <= CRC_INIT;
            r_held   <= '0;
            r_sticky <= ST_OK;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_flags  <= n_flags;
            r_extra  <= n_extra;
            r_crc    <= n_crc;
            r_held   <= n_held;
            r_sticky <= n_sticky;
        end
    end

    // a new member clears all state before the byte is parsed
    always_comb begin
        if (i_item.member_start) begin
            e_phase  = PH_FIXED;
            e_cnt    = '0;
            e_flags  = '0;
            e_extra  = '0;
            e_crc    = CRC_INIT;
            e_held   = '0;
            e_sticky = ST_OK;
        end else begin
            e_phase  = r_phase;
            e_cnt    = r_cnt;
            e_flags  = r_flags;
            e_extra  = r_extra;
            e_crc    = r_crc;
            e_held   = r_held;
            e_sticky = r_sticky;
        end
    end

    assign b = i_item.data_byte;
    assign w_crc_fed = crc_byte(e_crc, b);
    assign w_word = {b, e_held};

    // next state and result for one byte
    always_comb begin
        n_phase  = e_phase;
        n_cnt    = e_cnt;
        n_flags  = e_flags;
        n_extra  = e_extra;
        n_crc    = e_crc;
        n_held   = e_held;
        n_sticky = e_sticky;
        o_res.data_out      = b;
        o_res.payload_valid = 1'b0;
        o_res.header_done   = 1'b0;
        o_res.status        = ST_OK;
        case (e_phase)
            PH_FIXED: begin
                n_crc = w_crc_fed;
                if (e_cnt == 4'd0) n_held = b;
                if (e_cnt == 4'd1 && (e_held != MAGIC_0 || b != MAGIC_1)) begin
                    n_sticky = i_item.later_member ? ST_END : ST_BAD_MAGIC;
                    n_phase  = PH_STOP;
                    o_res.status = n_sticky;
                end else begin
                    if (e_cnt == 4'd3) n_flags = b[4:0];
                    if (e_cnt >= FIXED_LAST) begin
                        n_phase = next_sec(PH_FIXED, n_flags);
                        n_cnt   = '0;
                    end else begin
                        n_cnt = e_cnt + 4'd1;
                    end
                end
            end
            PH_XLEN: begin
                n_crc = w_crc_fed;
                if (e_cnt == 4'd0) begin
                    n_held = b;
                    n_cnt  = 4'd1;
                end else begin
                    n_extra = w_word & LOW16_MASK;
                    n_cnt   = '0;
                    n_phase = (w_word == 16'd0) ? next_sec(PH_EXTRA, e_flags) : PH_EXTRA;
                end
            end
            PH_EXTRA: begin
                n_crc = w_crc_fed;
                if (e_extra <= 16'd1) begin
                    n_extra = '0;
                    n_cnt   = '0;
                    n_phase = next_sec(PH_EXTRA, e_flags);
                end else begin
                    n_extra = e_extra - 16'd1;
                end
            end
            PH_NAME, PH_COMMENT: begin
                n_crc = w_crc_fed;
                if (b == 8'd0) begin
                    n_cnt   = '0;
                    n_phase = next_sec(e_phase, e_flags);
                end
            end
            PH_HCRC: begin
                if (e_cnt == 4'd0) begin
                    n_held = b;
                    n_cnt  = 4'd1;
                end else if ((~e_crc[15:0]) != w_word) begin
                    n_sticky = ST_CRC_ERR;
                    n_phase  = PH_STOP;
                    o_res.status = ST_CRC_ERR;
                end else begin
                    n_cnt   = '0;
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                o_res.payload_valid = 1'b1;
            end
            default: begin
                o_res.status = e_sticky;
            end
        endcase
        // entering payload ends the header and restarts the crc
        if (n_phase == PH_PAYLOAD && e_phase != PH_PAYLOAD) begin
            n_crc = CRC_INIT;
            o_res.header_done = 1'b1;
        end
    end

    // header end always lands in payload
    a_done_to_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && o_res.header_done |=> r_phase == PH_PAYLOAD)
        else $error("header end did not enter payload");

    // stopped phase keeps a fault status
    a_stop_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_STOP |-> r_sticky != ST_OK)
        else $error("stopped without a fault status");

    // extra field count never empty while skipping
    a_extra_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_EXTRA |-> r_extra != 16'd0)
        else $error("extra phase with zero length left");

    // payload words never carry a fault
    a_payload_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && o_res.payload_valid |-> o_res.status == ST_OK && !o_res.header_done)
        else $error("payload word with status or header end");

endmodule

// ----- hw/rtl/gzip_member_header_parser_core.sv -----
// gzip member header parser, one stream byte per word.
// slave channel: i_s_tdata carries the raw byte, i_s_tuser marks a new member
// header (bit 0) and whether a valid member came before it (bit 1).
// master channel: one result word per input word, the byte passed through,
// o_m_tlast on the last byte of a header, payload and status flags in o_m_tuser.
// status: 0 ok, 1 bad magic, 2 header crc mismatch, 3 end of members. after a
// fault the parser stays stopped until the next word flagged as a member start.
// pipeline: input register, then result register with the parse logic between
// them; o_m_tvalid comes from the result register.
// throughput: one word per cycle while the receiver takes results; the header
// crc is a full byte-wide crc-32 update of each byte, so no header byte stalls.
// reset (i_rst_n low, synchronous) empties both registers and returns the
// parser to the fixed header phase with the crc at its initial value.
// when the receiver stalls, the result register holds and the input register
// still takes one more word; the slave side then stalls until the result moves.
module gzip_member_header_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // data_byte
    input  logic [1:0] i_s_tuser,   // member_start, later_member
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // data_out
    output logic       o_m_tlast,   // header_done
    output logic [2:0] o_m_tuser    // payload_valid, status[1:0]
);
    import gzhp_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_res;
    t_result w_res;
    logic    w_adv;

    assign w_adv      = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item <= '{later_member: i_s_tuser[1], member_start: i_s_tuser[0],
                        data_byte: i_s_tdata};
        end
    end

    gzhp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_in_valid && w_adv),
        .i_item  (r_item),
        .o_res   (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_valid) begin
            r_res <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_res.data_out;
    assign o_m_tlast  = r_res.header_done;
    assign o_m_tuser  = {r_res.status, r_res.payload_valid};

endmodule
